// ===== rtl/afsn_pkg.sv =====
package afsn_pkg;

   // Field geometry
   localparam int FIELD_CHARS      = 8;
   localparam int POS_W            = 3;
   localparam int CNT_W            = 4;
   localparam int DIGITS_PER_STAGE = 2;
   localparam int ACC_STAGES       = FIELD_CHARS / DIGITS_PER_STAGE;

   // Result geometry
   localparam int ACC_W    = 32;
   localparam int MANT_W   = 29;
   localparam int MAG_W    = MANT_W - 1;
   localparam int PLACES_W = 3;
   localparam int D_W      = 5;
   localparam logic [MAG_W-1:0] MANT_LIMIT = 28'd268435455;

   // Characters of interest
   localparam logic [7:0] CH_NUL      = 8'h00;
   localparam logic [7:0] CH_TAB      = 8'h09;
   localparam logic [7:0] CH_CR       = 8'h0D;
   localparam logic [7:0] CH_SPACE    = 8'h20;
   localparam logic [7:0] CH_PLUS     = 8'h2B;
   localparam logic [7:0] CH_MINUS    = 8'h2D;
   localparam logic [7:0] CH_DOT      = 8'h2E;
   localparam logic [7:0] CH_ZERO     = 8'h30;
   localparam logic [7:0] CH_NINE     = 8'h39;
   localparam logic [7:0] CH_HEX_MARK = 8'h3E;
   localparam logic [7:0] CH_UP_A     = 8'h41;
   localparam logic [7:0] CH_UP_F     = 8'h46;
   localparam logic [7:0] CH_UP_X     = 8'h58;
   localparam logic [7:0] CH_LOW_A    = 8'h61;
   localparam logic [7:0] CH_LOW_F    = 8'h66;
   localparam logic [7:0] CH_LOW_X    = 8'h78;

   typedef logic [7:0] char_type;
   typedef logic [3:0] digit_type;

   // Payload carried through the accumulation stages
   typedef struct packed {
      logic [ACC_W-1:0]                    acc;
      digit_type [FIELD_CHARS-1:0]         dv;
      logic [FIELD_CHARS-1:0]              sel;
      logic                                hex;
      logic                                neg;
      logic [PLACES_W-1:0]                 places;
      logic                                bad;
   } acc_pipe_type;

   function automatic logic is_hex_digit(char_type c);
      return (c >= CH_ZERO && c <= CH_NINE) || (c >= CH_LOW_A && c <= CH_LOW_F) ||
             (c >= CH_UP_A && c <= CH_UP_F);
   endfunction

   function automatic digit_type digit_value(char_type c);
      digit_type v;
      v = '0;
      if (c >= CH_ZERO && c <= CH_NINE) begin
         v = digit_type'(c - CH_ZERO);
      end else if (c >= CH_LOW_A && c <= CH_LOW_F) begin
         v = digit_type'(c - CH_LOW_A + 8'd10);
      end else if (c >= CH_UP_A && c <= CH_UP_F) begin
         v = digit_type'(c - CH_UP_A + 8'd10);
      end
      return v;
   endfunction

   function automatic logic is_white(char_type c);
      return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
   endfunction

endpackage

// ===== rtl/ascii_field_to_scaled_number_core.sv =====
// Converts an 8-character ASCII field into a signed mantissa and a count of
// decimal places (value = mantissa / 10^places). One request is taken every
// clock while the chain is not stalled; each accepted request passes through
// a chain of registers: marker/terminator scan, start-of-digits search,
// digit selection with point tracking, four digit-folding stages of two
// characters each, and the sign/saturation output register. A stalled
// result holds the chain only as far back as there are occupied stages, so
// bubbles are squeezed out and a full chain still accepts a request in the
// cycle the result is taken.
module ascii_field_to_scaled_number_core #(
   parameter int MAX_PLACES = 5
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [7:0]                           req_ch0,
   input  logic [7:0]                           req_ch1,
   input  logic [7:0]                           req_ch2,
   input  logic [7:0]                           req_ch3,
   input  logic [7:0]                           req_ch4,
   input  logic [7:0]                           req_ch5,
   input  logic [7:0]                           req_ch6,
   input  logic [7:0]                           req_ch7,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [afsn_pkg::MANT_W-1:0]   rsp_mantissa,
   output logic [afsn_pkg::PLACES_W-1:0]        rsp_decimal_places,
   output logic                                 rsp_bad_char
);
   import afsn_pkg::*;

   localparam int STAGES = 3 + ACC_STAGES + 1;
   localparam logic signed [D_W-1:0] D_ONE = D_W'(1);
   localparam logic signed [D_W-1:0] D_MAX = D_W'(MAX_PLACES);

   // Pipeline control
   logic [STAGES-1:0] valid_ff;
   logic [STAGES-1:0] valid_in;
   logic [STAGES-1:0] valid_src;
   logic [STAGES-1:0] adv;

   // Stage 1 registers
   char_type [FIELD_CHARS-1:0] ch_req;
   char_type [FIELD_CHARS-1:0] s1_char_in, s1_char_ff;
   logic [FIELD_CHARS-1:0]     s1_inlen_in, s1_inlen_ff;
   logic                       s1_int_in, s1_int_ff;
   logic                       s1_hex_in, s1_hex_ff;

   // Stage 2 registers
   digit_type [FIELD_CHARS-1:0] s2_dv_in, s2_dv_ff;
   logic [FIELD_CHARS-1:0]      s2_okdig_in, s2_okdig_ff;
   logic [FIELD_CHARS-1:0]      s2_dot_in, s2_dot_ff;
   logic [FIELD_CHARS-1:0]      s2_inlen_ff;
   logic                        s2_int_ff, s2_hex_ff;
   logic                        s2_neg_in, s2_neg_ff;
   logic [CNT_W-1:0]            s2_start_in, s2_start_ff;

   // Stage 3 and accumulation chain
   acc_pipe_type            s3_in, s3_ff;
   logic [FIELD_CHARS-1:0]  s3_sel_c;
   acc_pipe_type            acc_q [ACC_STAGES+1];

   // Output stage
   logic [MAG_W-1:0]           out_mag;
   logic signed [MANT_W-1:0]   rsp_mantissa_in, rsp_mantissa_ff;
   logic [PLACES_W-1:0]        rsp_places_ff;
   logic                       rsp_bad_ff;

   assign ch_req = {req_ch7, req_ch6, req_ch5, req_ch4, req_ch3, req_ch2, req_ch1, req_ch0};

   // Advance a stage when it is empty or its successor advances
   always_comb begin
      adv[STAGES-1] = !valid_ff[STAGES-1] || rsp_ready;
      for (int k = STAGES - 2; k >= 0; k--) begin
         adv[k] = !valid_ff[k] || adv[k+1];
      end
   end

   assign valid_src = {valid_ff[STAGES-2:0], req_valid};
   assign valid_in  = (adv & valid_src) | (~adv & valid_ff);
   assign req_ready = adv[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Stage 1: find the terminator, note any point, replace the first hex marker
   always_comb begin
      logic run;
      logic mark_seen;
      logic dot_seen;
      run        = 1'b1;
      mark_seen  = 1'b0;
      dot_seen   = 1'b0;
      s1_char_in = ch_req;
      for (int i = 0; i < FIELD_CHARS; i++) begin
         run            = run && (ch_req[i] != CH_NUL);
         s1_inlen_in[i] = run;
         if (run && ch_req[i] == CH_DOT) begin
            dot_seen = 1'b1;
         end
         if (run && !mark_seen && ch_req[i] == CH_HEX_MARK) begin
            s1_char_in[i] = CH_SPACE;
            mark_seen     = 1'b1;
         end
      end
      s1_hex_in = mark_seen;
      s1_int_in = !dot_seen || mark_seen;
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         s1_char_ff  <= s1_char_in;
         s1_inlen_ff <= s1_inlen_in;
         s1_int_ff   <= s1_int_in;
         s1_hex_ff   <= s1_hex_in;
      end
   end

   // Stage 2: classify characters and locate the first digit of the number
   always_comb begin
      logic                   found;
      logic                   skip;
      logic [CNT_W-1:0]       w;
      logic [CNT_W-1:0]       p1;
      logic [CNT_W-1:0]       pn;
      logic [CNT_W-1:0]       q;
      char_type               cw;
      logic [FIELD_CHARS-1:0] xd;
      for (int i = 0; i < FIELD_CHARS; i++) begin
         xd[i]          = is_hex_digit(s1_char_ff[i]);
         s2_dv_in[i]    = digit_value(s1_char_ff[i]);
         s2_okdig_in[i] = xd[i] && (s1_hex_ff || s2_dv_in[i] < 4'd10);
         s2_dot_in[i]   = s1_char_ff[i] == CH_DOT;
      end

      // skip leading white space (integer) or spaces (decimal)
      found = 1'b0;
      w     = CNT_W'(FIELD_CHARS);
      for (int i = 0; i < FIELD_CHARS; i++) begin
         if (s1_int_ff) begin
            skip = s1_inlen_ff[i] && is_white(s1_char_ff[i]);
         end else begin
            skip = s1_char_ff[i] == CH_SPACE;
         end
         if (!found && !skip) begin
            w     = CNT_W'(i);
            found = 1'b1;
         end
      end

      // optional sign
      s2_neg_in = 1'b0;
      p1        = w;
      cw        = s1_char_ff[w[POS_W-1:0]];
      if (w < CNT_W'(FIELD_CHARS)) begin
         if (s1_int_ff) begin
            if (s1_inlen_ff[w[POS_W-1:0]] && (cw == CH_PLUS || cw == CH_MINUS)) begin
               s2_neg_in = cw == CH_MINUS;
               p1        = w + CNT_W'(1);
            end
         end else if (cw == CH_MINUS) begin
            s2_neg_in = 1'b1;
            p1        = w + CNT_W'(1);
         end
      end

      // hex prefix in integer mode, leading zeros in decimal mode
      pn          = p1 + CNT_W'(1);
      q           = p1 + CNT_W'(2);
      s2_start_in = p1;
      if (s1_int_ff) begin
         if (s1_hex_ff && q < CNT_W'(FIELD_CHARS) && s1_inlen_ff[q[POS_W-1:0]] &&
             s1_char_ff[p1[POS_W-1:0]] == CH_ZERO &&
             (s1_char_ff[pn[POS_W-1:0]] == CH_LOW_X ||
              s1_char_ff[pn[POS_W-1:0]] == CH_UP_X) &&
             xd[q[POS_W-1:0]]) begin
            s2_start_in = q;
         end
      end else begin
         found       = 1'b0;
         s2_start_in = CNT_W'(FIELD_CHARS);
         for (int i = 0; i < FIELD_CHARS; i++) begin
            if (CNT_W'(i) >= p1 && !found && s1_char_ff[i] != CH_ZERO) begin
               s2_start_in = CNT_W'(i);
               found       = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         s2_dv_ff    <= s2_dv_in;
         s2_okdig_ff <= s2_okdig_in;
         s2_dot_ff   <= s2_dot_in;
         s2_inlen_ff <= s1_inlen_ff;
         s2_int_ff   <= s1_int_ff;
         s2_hex_ff   <= s1_hex_ff;
         s2_neg_ff   <= s2_neg_in;
         s2_start_ff <= s2_start_in;
      end
   end

   // Stage 3: select the digits, track the point, flag an early stop
   always_comb begin
      logic                    run;
      logic                    bad;
      logic [CNT_W-1:0]        stop;
      logic signed [D_W-1:0]   d;
      run      = 1'b1;
      stop     = CNT_W'(FIELD_CHARS);
      d        = '0;
      s3_sel_c = '0;
      for (int i = 0; i < FIELD_CHARS; i++) begin
         if (CNT_W'(i) >= s2_start_ff && run) begin
            if (s2_int_ff) begin
               if (s2_inlen_ff[i] && s2_okdig_ff[i]) begin
                  s3_sel_c[i] = 1'b1;
               end else begin
                  run = 1'b0;
               end
            end else if (s2_okdig_ff[i]) begin
               s3_sel_c[i] = 1'b1;
            end else if (s2_dot_ff[i]) begin
               d = D_W'(FIELD_CHARS - 1 - i);
            end else begin
               run  = 1'b0;
               stop = CNT_W'(i);
            end
         end
      end
      bad = !s2_int_ff && !run;
      // an early stop pulls the point back by the unread characters
      if (bad && d != '0) begin
         d = d - $signed(D_W'(FIELD_CHARS) - D_W'(stop));
      end
      s3_in.acc    = '0;
      s3_in.dv     = s2_dv_ff;
      s3_in.sel    = s3_sel_c;
      s3_in.hex    = s2_hex_ff;
      s3_in.neg    = s2_neg_ff;
      s3_in.bad    = bad;
      s3_in.places = (d >= D_ONE && d <= D_MAX) ? d[PLACES_W-1:0] : '0;
   end

   always_ff @(posedge clock) begin
      if (adv[2]) begin
         s3_ff <= s3_in;
      end
   end

   assign acc_q[0] = s3_ff;

   // Stages 4 to 7: fold two characters per stage
   for (genvar g = 0; g < ACC_STAGES; g++) begin : g_acc
      afsn_acc_stage #(
         .FIRST(g * DIGITS_PER_STAGE)
      ) u_acc_stage (
         .clock (clock),
         .load  (adv[3 + g]),
         .d_in  (acc_q[g]),
         .q_ff  (acc_q[g + 1])
      );
   end

   // Output stage: saturate, apply the sign
   always_comb begin
      if (acc_q[ACC_STAGES].acc > ACC_W'(MANT_LIMIT)) begin
         out_mag = MANT_LIMIT;
      end else begin
         out_mag = acc_q[ACC_STAGES].acc[MAG_W-1:0];
      end
      if (acc_q[ACC_STAGES].neg) begin
         rsp_mantissa_in = -$signed({1'b0, out_mag});
      end else begin
         rsp_mantissa_in = $signed({1'b0, out_mag});
      end
   end

   always_ff @(posedge clock) begin
      if (adv[STAGES-1]) begin
         rsp_mantissa_ff <= rsp_mantissa_in;
         rsp_places_ff   <= acc_q[ACC_STAGES].places;
         rsp_bad_ff      <= acc_q[ACC_STAGES].bad;
      end
   end

   assign rsp_valid          = valid_ff[STAGES-1];
   assign rsp_mantissa       = rsp_mantissa_ff;
   assign rsp_decimal_places = rsp_places_ff;
   assign rsp_bad_char       = rsp_bad_ff;

   // Integer-mode digits form one unbroken run
   a_int_run_contiguous : assert property (@(posedge clock) disable iff (reset)
      valid_ff[1] && s2_int_ff |-> ((s3_sel_c + (s3_sel_c & -s3_sel_c)) & s3_sel_c) == '0)
      else $error("integer digit selection has a gap");

   // Scale stays within the configured number of places
   a_places_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_decimal_places <= PLACES_W'(MAX_PLACES))
      else $error("decimal places beyond limit");

   // Saturation never yields the most negative code
   a_mant_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_mantissa != {1'b1, {MAG_W{1'b0}}})
      else $error("mantissa outside saturation range");

   // A blocked middle stage keeps its request
   a_stage_hold : assert property (@(posedge clock) disable iff (reset)
      valid_ff[2] && !adv[2] |=> valid_ff[2] && $stable(acc_q[0]))
      else $error("stalled request lost or altered");

endmodule

// ===== rtl/afsn_acc_stage.sv =====
module afsn_acc_stage #(
   parameter int FIRST = 0
) (
   input  logic                   clock,
   input  logic                   load,
   input  afsn_pkg::acc_pipe_type d_in,
   output afsn_pkg::acc_pipe_type q_ff
);
   import afsn_pkg::*;

   acc_pipe_type q_in;

   // Fold this stage's digit positions into the running value
   always_comb begin
      q_in = d_in;
      for (int k = 0; k < DIGITS_PER_STAGE; k++) begin
         if (d_in.sel[FIRST + k]) begin
            if (d_in.hex) begin
               q_in.acc = {q_in.acc[ACC_W-5:0], d_in.dv[FIRST + k]};
            end else begin
               q_in.acc = (q_in.acc << 3) + (q_in.acc << 1) + ACC_W'(d_in.dv[FIRST + k]);
            end
         end
      end
   end

   // Hold while the next stage is blocked
   always_ff @(posedge clock) begin
      if (load) begin
         q_ff <= q_in;
      end
   end

endmodule
